FILE: design/cau_pkg.sv
// Shared widths, opcodes, pipeline word types and saturation helper for the complex ALU.
package cau_pkg;

    localparam int DW    = 32;            // part width
    localparam int FB    = 16;            // fraction bits
    localparam int PW    = 2 * DW;        // product width
    localparam int SW    = PW + 1;        // sum of two products
    localparam int RW    = PW + DW;       // divider remainder width
    localparam int NCELL = DW;            // one quotient bit per cell

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    // One divide lane: partial remainder, shifted divisor, quotient so far.
    typedef struct packed {
        logic [RW-1:0] rem;
        logic [RW-1:0] dsh;
        logic [DW-1:0] q;
        logic          neg;
        logic          big;
    } t_lane;

    // Results already final for add, subtract and multiply; divide status.
    typedef struct packed {
        logic          is_div;
        logic          dz;
        logic [DW-1:0] re;
        logic [DW-1:0] im;
        logic          ovf;
    } t_side;

    typedef struct packed {
        t_lane re_l;
        t_lane im_l;
        t_side side;
    } t_word;

    localparam logic signed [SW-1:0] SMAX = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};

    // Clamp a wide signed value to DW bits; top bit of the result flags clamping.
    function automatic logic [DW:0] sat_wide(input logic signed [SW-1:0] x);
        logic [DW:0] r;
        if (x > SMAX) begin
            r = {1'b1, SMAX[DW-1:0]};
        end else if (x < SMIN) begin
            r = {1'b1, SMIN[DW-1:0]};
        end else begin
            r = {1'b0, x[DW-1:0]};
        end
        return r;
    endfunction

endpackage

FILE: design/cau_front.sv
// Front pipeline: products, sums, add/sub/mul results and divider setup.
module cau_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  cau_pkg::t_op         i_op,
    input  logic signed [31:0]   i_ar,
    input  logic signed [31:0]   i_ai,
    input  logic signed [31:0]   i_br,
    input  logic signed [31:0]   i_bi,
    output logic                 o_valid,
    input  logic                 i_ready,
    output cau_pkg::t_word       o_word
);
    import cau_pkg::*;

    logic                 r1_v, r2_v, r3_v;
    logic                 rdy1, rdy2, rdy3;
    t_op                  r1_op, r2_op;
    logic signed [PW-1:0] r1_rr, r1_ii, r1_ri, r1_ir, r1_br2, r1_bi2;
    logic signed [DW:0]   r1_sre, r1_sim, n_sre, n_sim;
    logic signed [SW-1:0] r2_mre, r2_mim, r2_nre, r2_nim;
    logic [PW-1:0]        r2_den;
    logic signed [DW:0]   r2_sre, r2_sim;
    t_word                r3_word, n_word;

    assign rdy3    = !r3_v || i_ready;
    assign rdy2    = !r2_v || rdy3;
    assign rdy1    = !r1_v || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r3_v;
    assign o_word  = r3_word;

    always_comb begin
        if (i_op == OP_SUB) begin
            n_sre = {i_ar[DW-1], i_ar} - {i_br[DW-1], i_br};
            n_sim = {i_ai[DW-1], i_ai} - {i_bi[DW-1], i_bi};
        end else begin
            n_sre = {i_ar[DW-1], i_ar} + {i_br[DW-1], i_br};
            n_sim = {i_ai[DW-1], i_ai} + {i_bi[DW-1], i_bi};
        end
    end

    // Numerator magnitude shifted up by the fraction bits, divisor aligned to quotient bit 31.
    function automatic t_lane div_setup(input logic signed [SW-1:0] num,
                                        input logic [PW-1:0] den);
        t_lane         l;
        logic [SW-1:0] m;
        logic [RW-1:0] nw;
        logic [RW-1:0] dw;
        m     = num[SW-1] ? -num : num;
        nw    = {{(RW-PW){1'b0}}, m[PW-1:0]} << FB;
        dw    = {{(RW-PW){1'b0}}, den};
        l.rem = nw;
        l.dsh = dw << (DW-1);
        l.q   = '0;
        l.neg = num[SW-1];
        l.big = nw >= (dw << DW);
        return l;
    endfunction

    always_comb begin
        logic [DW:0]          sr, si;
        logic signed [SW-1:0] shr, shi;
        shr = r2_mre >>> FB;
        shi = r2_mim >>> FB;
        sr  = '0;
        si  = '0;
        n_word.re_l        = div_setup(r2_nre, r2_den);
        n_word.im_l        = div_setup(r2_nim, r2_den);
        n_word.side.is_div = 1'b0;
        n_word.side.dz     = 1'b0;
        unique case (r2_op)
            OP_ADD, OP_SUB: begin
                sr = sat_wide({{(SW-DW-1){r2_sre[DW]}}, r2_sre});
                si = sat_wide({{(SW-DW-1){r2_sim[DW]}}, r2_sim});
            end
            OP_MUL: begin
                sr = sat_wide(shr);
                si = sat_wide(shi);
            end
            OP_DIV: begin
                n_word.side.is_div = 1'b1;
                n_word.side.dz     = (r2_den == '0);
            end
            default: begin
                sr = '0;
                si = '0;
            end
        endcase
        n_word.side.re  = sr[DW-1:0];
        n_word.side.im  = si[DW-1:0];
        n_word.side.ovf = sr[DW] | si[DW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (rdy1) r1_v <= i_valid;
            if (rdy2) r2_v <= r1_v;
            if (rdy3) r3_v <= r2_v;
        end
        if (rdy1) begin
            r1_op  <= i_op;
            r1_rr  <= i_ar * i_br;
            r1_ii  <= i_ai * i_bi;
            r1_ri  <= i_ar * i_bi;
            r1_ir  <= i_ai * i_br;
            r1_br2 <= i_br * i_br;
            r1_bi2 <= i_bi * i_bi;
            r1_sre <= n_sre;
            r1_sim <= n_sim;
        end
        if (rdy2) begin
            r2_op  <= r1_op;
            r2_mre <= {r1_rr[PW-1], r1_rr} - {r1_ii[PW-1], r1_ii};
            r2_mim <= {r1_ri[PW-1], r1_ri} + {r1_ir[PW-1], r1_ir};
            r2_nre <= {r1_rr[PW-1], r1_rr} + {r1_ii[PW-1], r1_ii};
            r2_nim <= {r1_ir[PW-1], r1_ir} - {r1_ri[PW-1], r1_ri};
            r2_den <= unsigned'(r1_br2) + unsigned'(r1_bi2);
            r2_sre <= r1_sre;
            r2_sim <= r1_sim;
        end
        if (rdy3) r3_word <= n_word;
    end

endmodule

FILE: design/cau_div_cell.sv
// Divider cell: one restoring step per lane, one quotient bit per cell.
module cau_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  cau_pkg::t_word i_word,
    output logic           o_valid,
    input  logic           i_ready,
    output cau_pkg::t_word o_word
);
    import cau_pkg::*;

    logic  r_v;
    t_word r_word, n_word;

    function automatic t_lane step(input t_lane l);
        t_lane r;
        r = l;
        if (l.rem >= l.dsh) begin
            r.rem = l.rem - l.dsh;
            r.q   = {l.q[DW-2:0], 1'b1};
        end else begin
            r.q   = {l.q[DW-2:0], 1'b0};
        end
        r.dsh = l.dsh >> 1;
        return r;
    endfunction

    always_comb begin
        n_word      = i_word;
        n_word.re_l = step(i_word.re_l);
        n_word.im_l = step(i_word.im_l);
    end

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
        if (o_ready) r_word <= n_word;
    end

endmodule

FILE: design/cau_out.sv
// Output stage: divide sign and saturation, result register.
module cau_out (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  cau_pkg::t_word i_word,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [31:0]    o_re,
    output logic [31:0]    o_im,
    output logic           o_ovf,
    output logic           o_dz
);
    import cau_pkg::*;

    logic          r_v;
    logic [DW-1:0] r_re, r_im, n_re, n_im;
    logic          r_ovf, r_dz, n_ovf;

    // Quotient may reach 2^(DW-1) only when negative.
    function automatic logic [DW:0] finish(input t_lane l);
        logic          o;
        logic [DW-1:0] v;
        o = l.big || (l.q[DW-1] && (!l.neg || (l.q[DW-2:0] != '0)));
        if (o) begin
            v = l.neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end else begin
            v = l.neg ? -l.q : l.q;
        end
        return {o, v};
    endfunction

    always_comb begin
        logic [DW:0] fr, fi;
        fr = finish(i_word.re_l);
        fi = finish(i_word.im_l);
        if (!i_word.side.is_div) begin
            n_re  = i_word.side.re;
            n_im  = i_word.side.im;
            n_ovf = i_word.side.ovf;
        end else if (i_word.side.dz) begin
            n_re  = '0;
            n_im  = '0;
            n_ovf = 1'b0;
        end else begin
            n_re  = fr[DW-1:0];
            n_im  = fi[DW-1:0];
            n_ovf = fr[DW] | fi[DW];
        end
    end

    assign o_ready = !r_v || !i_stall;
    assign o_valid = r_v;
    assign o_re    = r_re;
    assign o_im    = r_im;
    assign o_ovf   = r_ovf;
    assign o_dz    = r_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
        if (o_ready) begin
            r_re  <= n_re;
            r_im  <= n_im;
            r_ovf <= n_ovf;
            r_dz  <= i_word.side.is_div & i_word.side.dz;
        end
    end

endmodule

FILE: design/complex_arith_unit.sv
// Complex ALU: add, subtract, multiply, divide on signed Q16.16 parts.
// A word passes the front registers, a row of 32 divider cells and the output register.
// Throughput: one word per cycle while not stalled; each divider cell makes one quotient bit.
// Every stage holds its own valid, so bubbles close up while the output is stalled.
// Reset (synchronous, active low) clears all valid flags; data registers are not reset.
module complex_arith_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_opcode,
    input  logic signed [31:0] i_a_real,
    input  logic signed [31:0] i_a_imag,
    input  logic signed [31:0] i_b_real,
    input  logic signed [31:0] i_b_imag,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_res_real,
    output logic signed [31:0] o_res_imag,
    output logic               o_overflow,
    output logic               o_divide_by_zero
);
    import cau_pkg::*;

    logic  v   [0:NCELL];
    logic  rdy [0:NCELL];
    t_word w   [0:NCELL];
    logic  front_rdy;
    t_op   op;

    assign op      = t_op'(i_opcode);
    assign o_stall = !front_rdy;

    cau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (front_rdy),
        .i_op    (op),
        .i_ar    (i_a_real),
        .i_ai    (i_a_imag),
        .i_br    (i_b_real),
        .i_bi    (i_b_imag),
        .o_valid (v[0]),
        .i_ready (rdy[0]),
        .o_word  (w[0])
    );

    for (genvar c = 0; c < NCELL; c++) begin : g_cell
        cau_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v[c]),
            .o_ready (rdy[c]),
            .i_word  (w[c]),
            .o_valid (v[c+1]),
            .i_ready (rdy[c+1]),
            .o_word  (w[c+1])
        );
    end

    cau_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v[NCELL]),
        .o_ready (rdy[NCELL]),
        .i_word  (w[NCELL]),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_re    (o_res_real),
        .o_im    (o_res_imag),
        .o_ovf   (o_overflow),
        .o_dz    (o_divide_by_zero)
    );

endmodule

FILE: design/cau_checker.sv
// Port-level checks for the complex ALU, bound to the top level.
module cau_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_res_real,
    input logic [31:0] o_res_imag,
    input logic        o_overflow,
    input logic        o_divide_by_zero
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid word after reset");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("stalled word dropped");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_res_real) && $stable(o_res_imag))
        else $error("stalled word changed");

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divide_by_zero |->
            o_res_real == 32'd0 && o_res_imag == 32'd0 && !o_overflow)
        else $error("zero divisor result not cleared");

endmodule

bind complex_arith_unit cau_checker u_cau_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_res_real       (o_res_real),
    .o_res_imag       (o_res_imag),
    .o_overflow       (o_overflow),
    .o_divide_by_zero (o_divide_by_zero)
);
